// ----- hw/rtl/sct_pkg.sv -----
// shared types and character constants for the source comment stripper
`timescale 1ns / 1ps

package sct_pkg;

  // scanner modes
  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_SLASH  = 3'd1,
    MODE_LINE   = 3'd2,
    MODE_BLOCK  = 3'd3,
    MODE_BSTAR  = 3'd4
  } scan_mode_t;

  // scanner state carried from byte to byte
  typedef struct packed {
    scan_mode_t  scan_mode;
    logic        inside_parens;
    logic        quote_protect;
    logic [7:0]  previous_char;
  } scan_state_t;

  // one result byte with its run marker
  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
  } result_t;

  localparam scan_state_t STATE_RESET = '{
    scan_mode:     MODE_NORMAL,
    inside_parens: 1'b0,
    quote_protect: 1'b0,
    previous_char: 8'h00
  };

  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;

endpackage

// ----- hw/rtl/sct_step.sv -----
// combinational scanner step: one input byte to zero, one or two result bytes
`timescale 1ns / 1ps

module sct_step (
  input  logic [7:0]          in_char,
  input  logic                final_byte,
  input  logic                drop_newlines,
  input  sct_pkg::scan_state_t cur_state,
  output sct_pkg::scan_state_t next_state,
  output logic [1:0]          res_count,
  output sct_pkg::result_t    res0,
  output sct_pkg::result_t    res1
);
  import sct_pkg::*;

  scan_state_t st;
  logic [1:0]  n;
  logic [7:0]  b0;
  logic [7:0]  b1;
  logic        drop_c;
  logic        ip_new;
  logic        qp_new;

  always_comb begin
    st     = cur_state;
    n      = 2'd0;
    b0     = CH_SLASH;
    b1     = in_char;
    drop_c = (in_char == CH_NL) && drop_newlines;
    ip_new = cur_state.inside_parens;
    qp_new = cur_state.quote_protect;

    unique case (cur_state.scan_mode)
      MODE_SLASH: begin
        if (in_char == CH_SLASH) begin
          st.scan_mode = MODE_LINE;
        end else if (in_char == CH_STAR) begin
          st.scan_mode = MODE_BLOCK;
        end else begin
          // lone slash: emit it and then the byte as it is, unless the byte is a dropped newline
          st.scan_mode = MODE_NORMAL;
          b0 = CH_SLASH;
          b1 = in_char;
          if (drop_c) begin
            n = 2'd1;
          end else begin
            n = 2'd2;
            st.previous_char = in_char;
          end
        end
      end
      MODE_LINE: begin
        if (in_char == CH_NL) begin
          st.scan_mode = MODE_NORMAL;
          b0 = in_char;
          if (!drop_c) begin
            n = 2'd1;
            st.previous_char = in_char;
          end
        end
      end
      MODE_BLOCK: begin
        if (in_char == CH_STAR) begin
          st.scan_mode = MODE_BSTAR;
        end
      end
      MODE_BSTAR: begin
        if (in_char == CH_SLASH) begin
          st.scan_mode = MODE_NORMAL;
          st.previous_char = CH_SLASH;
        end else if (in_char != CH_STAR) begin
          st.scan_mode = MODE_BLOCK;
        end
      end
      default: begin
        // normal text with paren and quote tracking
        st.scan_mode = MODE_NORMAL;
        if (in_char == CH_LPAR) begin
          ip_new = 1'b1;
        end
        if (in_char == CH_QUOTE && ip_new) begin
          qp_new = 1'b1;
        end
        if (in_char == CH_RPAR) begin
          qp_new = 1'b0;
          ip_new = 1'b0;
        end
        st.inside_parens = ip_new;
        st.quote_protect = qp_new;
        b0 = in_char;
        if (!qp_new && in_char == CH_SLASH) begin
          st.scan_mode = MODE_SLASH;
        end else if (!qp_new && in_char == CH_SPACE &&
                     cur_state.previous_char == CH_SPACE) begin
          // collapsed space
          st.previous_char = in_char;
        end else if (!drop_c) begin
          n = 2'd1;
          st.previous_char = in_char;
        end
      end
    endcase

    // end of text: flush a pending slash, then back to reset state
    if (final_byte) begin
      if (st.scan_mode == MODE_SLASH) begin
        if (n == 2'd0) begin
          b0 = CH_SLASH;
        end else begin
          b1 = CH_SLASH;
        end
        n = n + 2'd1;
      end
      st = STATE_RESET;
    end
  end

  assign next_state = st;
  assign res_count  = n;
  assign res0       = '{out_char: b0, last_of_run: (n == 2'd1)};
  assign res1       = '{out_char: b1, last_of_run: 1'b1};

endmodule

// ----- hw/rtl/source_comment_stripper.sv -----
// top level of the source comment stripper: scanner state and result queue
`timescale 1ns / 1ps

// Source comment stripper. Takes one byte of source text per transfer on the in_
// stream and gives the stripped text on the out_ stream, one byte per transfer,
// with out_tlast high on the last byte caused by an input byte (an input byte may
// cause none). Line and block comments are removed, space runs collapse, and a
// quoted string opened inside parentheses keeps slashes and spaces to the closing
// parenthesis. in_tlast marks the final byte of a text; it flushes a pending slash
// and returns the scanner to its reset state. A new byte is taken in every cycle:
// the scanner step is a single level of logic on a registered state, and results
// go to a four-entry queue. A byte that causes two results (a lone slash) always
// follows one that causes none, so with the output side taking a byte per cycle
// the queue never holds more than two and the input stalls only after the output
// side has stalled, until the queue is back down to two entries.
// cfg_we writes drop_newlines (1 removes newline bytes); write it only while idle.

module source_comment_stripper (
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_we,
  input  logic       cfg_wdata,     // drop_newlines
  // input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,      // [7:0] in_char
  input  logic       in_tlast,      // final_byte
  // result stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,     // [7:0] out_char
  output logic       out_tlast      // last_of_run
);
  import sct_pkg::*;

  localparam int QDEPTH = 4;

  logic        drop_nl_r;
  scan_state_t state_r;
  scan_state_t state_nxt;
  logic [1:0]  res_count;
  result_t     res0;
  result_t     res1;

  result_t     q_r [QDEPTH];
  result_t     q_nxt [QDEPTH];
  logic [2:0]  cnt_r;
  logic [2:0]  cnt_nxt;
  logic [2:0]  cnt_pop;
  logic [2:0]  cnt_pop1;
  logic        in_xfer;
  logic        out_xfer;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_nl_r <= 1'b0;
    end else if (cfg_we) begin
      drop_nl_r <= cfg_wdata;
    end
  end

  // scanner step
  sct_step u_step (
    .in_char       (in_tdata),
    .final_byte    (in_tlast),
    .drop_newlines (drop_nl_r),
    .cur_state     (state_r),
    .next_state    (state_nxt),
    .res_count     (res_count),
    .res0          (res0),
    .res1          (res1)
  );

  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;

  // scanner state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (in_xfer) begin
      state_r <= state_nxt;
    end
  end

  // room for two results regardless of the output side
  assign in_tready = (cnt_r <= 3'd2);

  // result queue: head at entry 0, pop shifts down, push behind the rest
  always_comb begin
    cnt_pop  = cnt_r - {2'b00, out_xfer};
    cnt_pop1 = cnt_pop + 3'd1;
    for (int i = 0; i < QDEPTH; i++) begin
      q_nxt[i] = q_r[i];
    end
    for (int i = 0; i < QDEPTH - 1; i++) begin
      if (out_xfer) begin
        q_nxt[i] = q_r[i + 1];
      end
    end
    for (int i = 0; i < QDEPTH; i++) begin
      if (in_xfer && res_count != 2'd0 && cnt_pop == 3'(i)) begin
        q_nxt[i] = res0;
      end
      if (in_xfer && res_count == 2'd2 && cnt_pop1 == 3'(i)) begin
        q_nxt[i] = res1;
      end
    end
    cnt_nxt = cnt_pop + (in_xfer ? {1'b0, res_count} : 3'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  assign out_tvalid = (cnt_r != 3'd0);
  assign out_tdata  = q_r[0].out_char;
  assign out_tlast  = q_r[0].last_of_run;

endmodule
